@@ rtl/binary_min_heap_core_macros.svh @@
// Assertion macros for the binary min-heap core
`ifndef BINARY_MIN_HEAP_CORE_MACROS_SVH
`define BINARY_MIN_HEAP_CORE_MACROS_SVH
// implication checked every clock outside reset
`define BMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define BMH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/bmh_pkg.sv @@
// Package for the binary min-heap core: status codes and command codes
`default_nettype none
package bmh_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;
endpackage
`default_nettype wire

@@ rtl/binary_min_heap_core.sv @@
// Binary min-heap core: one item at a time, heap held in a single-port RAM.
// Insert sifts the new key up; remove moves the last entry into the hole and sifts it up or
//   down; each step is paced by the one RAM port.
// Throughput: one item per result; a new word is taken the cycle after the result is taken.
// Reset: synchronous active-low rst_n empties the heap; RAM needs no clearing.
`default_nettype none
module binary_min_heap_core #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // [0] command, [KW:1] key_in, [KW+AW:KW+1] position, zero fill
  input  wire logic [((1+KEY_WIDTH+$clog2(DEPTH)+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // [KW-1:0] removed_key, [KW+1:KW] status, [KW+CW+1:KW+2] count, zero fill
  output logic [((KEY_WIDTH+2+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int OW = ((KEY_WIDTH+2+CW+7)/8)*8;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDP   = 10'b0000000010,  // read parent
    S_CMPU  = 10'b0000000100,  // compare with parent
    S_RDPOS = 10'b0000001000,  // read removed entry
    S_RDLST = 10'b0000010000,  // read last entry
    S_RDHP  = 10'b0000100000,  // read hole parent
    S_RDL   = 10'b0001000000,  // read left child
    S_RDR   = 10'b0010000000,  // read right child
    S_CMPD  = 10'b0100000000,  // pick child and compare
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW:0] at_r, at_nxt;        // one spare bit so child index can exceed
  logic [KEY_WIDTH-1:0] key_r, key_nxt, rem_r, rem_nxt, lc_r, lc_nxt;
  logic [1:0] st_r, st_nxt;
  logic up_r, up_nxt;               // remove: hole parent path pending
  logic we;
  logic [AW-1:0] addr;
  logic [KEY_WIDTH-1:0] wdata, rdata;

  wire logic cmd = in_tdata[0];
  wire logic [KEY_WIDTH-1:0] kin = in_tdata[KEY_WIDTH:1];
  wire logic [AW-1:0] pos = in_tdata[KEY_WIDTH+AW:KEY_WIDTH+1];

  logic [AW:0] par, lch;
  assign par = (at_r - 1'b1) >> 1;
  assign lch = {at_r[AW-1:0], 1'b1};

  bmh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; at_nxt = at_r; key_nxt = key_r;
    rem_nxt = rem_r; lc_nxt = lc_r; st_nxt = st_r; up_nxt = up_r;
    we = 1'b0; addr = at_r[AW-1:0]; wdata = key_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rem_nxt = '0; st_nxt = bmh_pkg::ST_OK;
          if (cmd == bmh_pkg::CMD_INSERT) begin
            if (cnt_r == CW'(DEPTH)) begin
              st_nxt = bmh_pkg::ST_FULL; state_nxt = S_OUT;
            end else begin
              key_nxt = kin; at_nxt = (AW+1)'(cnt_r); cnt_nxt = cnt_r + 1'b1;
              state_nxt = S_RDP;
            end
          end else if (CW'(pos) >= cnt_r) begin
            st_nxt = bmh_pkg::ST_INVALID; state_nxt = S_OUT;
          end else begin
            at_nxt = (AW+1)'(pos); cnt_nxt = cnt_r - 1'b1; state_nxt = S_RDPOS;
          end
        end
      end
      S_RDPOS: begin
        addr = at_r[AW-1:0]; state_nxt = S_RDLST;
      end
      S_RDLST: begin
        rem_nxt = rdata; addr = cnt_r[AW-1:0]; state_nxt = S_RDHP;
      end
      S_RDHP: begin
        key_nxt = rdata; addr = par[AW-1:0];
        up_nxt = (at_r != '0);
        state_nxt = (at_r != '0) ? S_CMPU : S_RDL;
      end
      S_RDP: begin
        // at_r==0 ends the sift
        if (at_r == '0) begin
          we = 1'b1; state_nxt = S_OUT;
        end else begin
          addr = par[AW-1:0]; state_nxt = S_CMPU;
        end
      end
      S_CMPU: begin
        if ($signed(rdata) > $signed(key_r)) begin
          up_nxt = 1'b0; we = 1'b1; wdata = rdata; at_nxt = par;
          state_nxt = S_RDP;
        end else if (up_r) begin
          up_nxt = 1'b0; state_nxt = S_RDL;
        end else begin
          we = 1'b1; state_nxt = S_OUT;
        end
      end
      S_RDL: begin
        if (lch >= (AW+1)'(cnt_r)) begin
          we = (at_r < (AW+1)'(DEPTH)); state_nxt = S_OUT;
        end else begin
          addr = lch[AW-1:0]; state_nxt = S_RDR;
        end
      end
      S_RDR: begin
        lc_nxt = rdata; addr = AW'(lch + 1'b1); state_nxt = S_CMPD;
      end
      S_CMPD: begin
        logic [KEY_WIDTH-1:0] ck;
        logic [AW:0] ci;
        ck = lc_r; ci = lch;
        if (lch + 1'b1 < (AW+1)'(cnt_r) && $signed(lc_r) > $signed(rdata)) begin
          ck = rdata; ci = lch + 1'b1;
        end
        if ($signed(key_r) <= $signed(ck)) begin
          we = 1'b1; state_nxt = S_OUT;
        end else begin
          we = 1'b1; wdata = ck; at_nxt = ci; state_nxt = S_RDL;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt;
    end
    at_r <= at_nxt; key_r <= key_nxt; rem_r <= rem_nxt; lc_r <= lc_nxt;
    st_r <= st_nxt; up_r <= up_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OW'({cnt_r, st_r, rem_r});
endmodule
`default_nettype wire

@@ rtl/bmh_ram.sv @@
// Generic single-port synchronous RAM with registered read
`default_nettype none
module bmh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/bmh_checker.sv @@
// Port-level checker for the binary min-heap core, with its bind
`default_nettype none
`include "binary_min_heap_core_macros.svh"
module bmh_checker #(
  parameter int OW = 32,
  parameter int KW = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [OW-1:0] out_tdata
);
  // input taken only when no result is pending
  `BMH_ASSERT_IMP(a_excl, clk, rst_n, out_tvalid, !in_tready, "ready while result pending")
  `BMH_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `BMH_ASSERT_IMP(a_stat, clk, rst_n, out_tvalid, out_tdata[KW+1:KW] != bmh_pkg::ST_INVALID || out_tdata[KW-1:0] == '0, "invalid remove gave key")
  // one word in flight at a time
  `BMH_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready right after accept")
endmodule

bind binary_min_heap_core bmh_checker #(.OW(OW), .KW(KEY_WIDTH)) u_bmh_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
